FILE: design/bcc_pkg.sv
// Shared types, codes and constants of the balance cascade controller.
package bcc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_TERM,
    ST_MID,
    ST_FIN
  } state_t;

  // Gain product selector, in the order the products are formed
  typedef enum logic [2:0] {
    MS_SPEED_KP = 3'd0,
    MS_SPEED_KI = 3'd1,
    MS_ANGLE_KP = 3'd2,
    MS_ANGLE_KD = 3'd3,
    MS_RATE_KP  = 3'd4,
    MS_RATE_KD  = 3'd5
  } mul_sel_t;

  localparam logic OP_SPEED    = 1'b0;
  localparam logic OP_ATTITUDE = 1'b1;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_SPEED_KP  = 3'd0;
  localparam logic [2:0] REG_SPEED_KI  = 3'd1;
  localparam logic [2:0] REG_ANGLE_KP  = 3'd2;
  localparam logic [2:0] REG_ANGLE_KD  = 3'd3;
  localparam logic [2:0] REG_RATE_KP   = 3'd4;
  localparam logic [2:0] REG_RATE_KD   = 3'd5;
  localparam logic [2:0] REG_ANGLE_REF = 3'd6;
  localparam logic [2:0] REG_RATE_OFF  = 3'd7;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;
  localparam int InDataW  = 88;
  localparam int OutDataW = 104;

  // Reset gains, signed Q16.32
  localparam logic signed [47:0] RST_SPEED_KP = 48'sd42949673;
  localparam logic signed [47:0] RST_SPEED_KI = 48'sd21475;
  localparam logic signed [47:0] RST_ANGLE_KP = -48'sd64424509440;
  localparam logic signed [47:0] RST_ANGLE_KD = -48'sd68719476736;
  localparam logic signed [47:0] RST_RATE_KP  = 48'sd644245094400;
  localparam logic signed [47:0] RST_RATE_KD  = 48'sd322122547200;

  // Speed output clamp bounds, Q.16
  localparam logic signed [63:0] SPD_HI_14 = 64'sd917504;
  localparam logic signed [63:0] SPD_LO_14 = -64'sd983040;
  localparam logic signed [63:0] SPD_HI_13 = 64'sd851968;
  localparam logic signed [63:0] SPD_LO_13 = -64'sd917504;

  // Integration window on the doubled speed error
  localparam logic signed [18:0] ERR2_WIN = 19'sd2000;

  typedef struct packed {
    logic     load;
    logic     prep;
    logic     mul;
    mul_sel_t sel;
    logic [1:0] digit;
    logic     term;
    logic     mid;
    logic     fin;
  } bcc_cmd_t;

  typedef struct packed {
    logic op;
  } bcc_stat_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -64'sh0000_8000_0000_0000;
    if (v > hi) return hi[47:0];
    else if (v < lo) return lo[47:0];
    else return v[47:0];
  endfunction

endpackage

FILE: design/bcc_ctrl.sv
// Sequencer of the balance cascade controller: item flow and multiply steps.
module bcc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  bcc_pkg::bcc_stat_t  stat,
  output bcc_pkg::bcc_cmd_t   cmd
);

  bcc_pkg::state_t   state_r, state_nxt;
  bcc_pkg::mul_sel_t mi_r, mi_nxt;
  logic [1:0]        dg_r, dg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              can_fin;

  assign can_fin = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bcc_pkg::ST_IDLE: if (in_tvalid) state_nxt = bcc_pkg::ST_PREP;
      bcc_pkg::ST_PREP: state_nxt = bcc_pkg::ST_MUL;
      bcc_pkg::ST_MUL:  if (dg_r == 2'd3) state_nxt = bcc_pkg::ST_TERM;
      bcc_pkg::ST_TERM: begin
        if (mi_r == bcc_pkg::MS_SPEED_KI || mi_r == bcc_pkg::MS_RATE_KD)
          state_nxt = bcc_pkg::ST_FIN;
        else if (mi_r == bcc_pkg::MS_ANGLE_KD)
          state_nxt = bcc_pkg::ST_MID;
        else
          state_nxt = bcc_pkg::ST_MUL;
      end
      bcc_pkg::ST_MID:  state_nxt = bcc_pkg::ST_MUL;
      bcc_pkg::ST_FIN:  if (can_fin) state_nxt = bcc_pkg::ST_IDLE;
      default:          state_nxt = bcc_pkg::ST_IDLE;
    endcase
  end

  // Product index and digit counter
  always_comb begin
    mi_nxt = mi_r;
    dg_nxt = 2'd0;
    case (state_r)
      bcc_pkg::ST_PREP: mi_nxt = (stat.op == bcc_pkg::OP_ATTITUDE) ?
                                 bcc_pkg::MS_ANGLE_KP : bcc_pkg::MS_SPEED_KP;
      bcc_pkg::ST_MUL:  dg_nxt = dg_r + 2'd1;
      bcc_pkg::ST_TERM: mi_nxt = bcc_pkg::mul_sel_t'(mi_r + 3'd1);
      default:          mi_nxt = mi_r;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    cmd.sel   = mi_r;
    cmd.digit = dg_r;
    in_tready = 1'b0;
    case (state_r)
      bcc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      bcc_pkg::ST_PREP: cmd.prep = 1'b1;
      bcc_pkg::ST_MUL:  cmd.mul  = 1'b1;
      bcc_pkg::ST_TERM: cmd.term = 1'b1;
      bcc_pkg::ST_MID:  cmd.mid  = 1'b1;
      bcc_pkg::ST_FIN:  cmd.fin  = can_fin;
      default:          cmd      = '0;
    endcase
  end

  // Hold the result valid until the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcc_pkg::ST_IDLE;
      mi_r        <= bcc_pkg::MS_SPEED_KP;
      dg_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mi_r        <= mi_nxt;
      dg_r        <= dg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/bcc_datapath.sv
// Datapath: configuration, loop state, shared digit multiplier and result register.
module bcc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [bcc_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [bcc_pkg::CfgDataW-1:0]        cfg_data,
  input  logic [bcc_pkg::InDataW-1:0]         in_tdata,
  input  logic                                in_tuser,
  output logic [bcc_pkg::OutDataW-1:0]        out_tdata,
  output logic                                out_tuser,
  input  bcc_pkg::bcc_cmd_t                   cmd,
  output bcc_pkg::bcc_stat_t                  stat
);

  // Configuration registers
  logic signed [47:0] speed_kp_r, speed_ki_r, angle_kp_r, angle_kd_r, rate_kp_r, rate_kd_r;
  logic signed [16:0] angle_ref_r;
  logic signed [15:0] rate_off_r;

  // Loop state
  logic signed [47:0] integral_r;
  logic signed [23:0] hold_r;
  logic signed [39:0] aprev_r;
  logic signed [47:0] rprev_r;
  logic               lim14_r;

  // Captured item
  logic               op_r;
  logic signed [15:0] left_r, right_r, target_r, gyro_r;
  logic signed [16:0] pitch_r;

  // Operands and sums
  logic signed [33:0]  e_r;
  logic signed [27:0]  a_r;
  logic signed [40:0]  da_r;
  logic signed [47:0]  g_r;
  logic signed [48:0]  dg_r;
  logic signed [47:0]  angle_r;
  logic signed [111:0] acc_r;
  logic signed [63:0]  sum_r;
  logic [bcc_pkg::OutDataW-1:0] out_tdata_r;
  logic                         out_tuser_r;

  assign stat.op = op_r;

  // Speed error and integral step
  logic signed [18:0] e2;
  logic signed [63:0] int_sum;
  assign e2 = 19'(left_r) + 19'(right_r) - (19'(target_r) <<< 1);
  assign int_sum = 64'(integral_r) + (64'(e2) <<< 15);

  // Angle error
  logic signed [27:0] a_v;
  assign a_v = (28'(pitch_r) <<< 8) - (28'(angle_ref_r) <<< 8) - 28'(hold_r);

  // Rate error
  logic signed [47:0] ang_v;
  logic signed [63:0] g_sum;
  logic signed [47:0] g_v;
  assign ang_v = bcc_pkg::sat48(sum_r);
  assign g_sum = 64'(ang_v) + ((64'(rate_off_r) - 64'(gyro_r)) <<< 16);
  assign g_v   = bcc_pkg::sat48(g_sum);

  // Operand selection for the shared multiplier
  logic signed [47:0] gain_m;
  logic signed [48:0] x_m;
  always_comb begin
    case (cmd.sel)
      bcc_pkg::MS_SPEED_KP: begin gain_m = speed_kp_r; x_m = 49'(e_r);        end
      bcc_pkg::MS_SPEED_KI: begin gain_m = speed_ki_r; x_m = 49'(integral_r); end
      bcc_pkg::MS_ANGLE_KP: begin gain_m = angle_kp_r; x_m = 49'(a_r);        end
      bcc_pkg::MS_ANGLE_KD: begin gain_m = angle_kd_r; x_m = 49'(da_r);       end
      bcc_pkg::MS_RATE_KP:  begin gain_m = rate_kp_r;  x_m = 49'(g_r);        end
      bcc_pkg::MS_RATE_KD:  begin gain_m = rate_kd_r;  x_m = dg_r;            end
      default:              begin gain_m = '0;         x_m = '0;              end
    endcase
  end

  // One 16-bit digit per cycle, top digit signed
  logic [63:0]         x64;
  logic [15:0]         dsl;
  logic signed [16:0]  d17;
  logic signed [64:0]  prod;
  logic signed [111:0] acc_nxt;
  assign x64  = {{15{x_m[48]}}, x_m};
  assign dsl  = x64[{cmd.digit, 4'b0} +: 16];
  assign d17  = $signed({(cmd.digit == 2'd3) & x64[63], dsl});
  assign prod = gain_m * d17;
  assign acc_nxt = ((cmd.digit == 2'd0) ? 112'sd0 : acc_r) +
                   ({{47{prod[64]}}, prod} <<< {cmd.digit, 4'b0});

  // Floor by 2^32 and limit the term
  logic signed [79:0] acc_sh;
  logic signed [62:0] term;
  assign acc_sh = acc_r[111:32];
  always_comb begin
    if (acc_sh > 80'sh0000_2000_0000_0000_0000)
      term = 63'sh2000_0000_0000_0000;
    else if (acc_sh < -80'sh0000_2000_0000_0000_0000)
      term = -63'sh2000_0000_0000_0000;
    else
      term = acc_sh[62:0];
  end

  // Speed clamp and drive saturation
  logic signed [63:0] hold_v;
  logic signed [47:0] d_sh;
  logic signed [31:0] drive_v;
  always_comb begin
    if (lim14_r) begin
      if (sum_r > bcc_pkg::SPD_HI_14) hold_v = bcc_pkg::SPD_HI_14;
      else if (sum_r < bcc_pkg::SPD_LO_14) hold_v = bcc_pkg::SPD_LO_14;
      else hold_v = sum_r;
    end else begin
      if (sum_r > bcc_pkg::SPD_HI_13) hold_v = bcc_pkg::SPD_HI_13;
      else if (sum_r < bcc_pkg::SPD_LO_13) hold_v = bcc_pkg::SPD_LO_13;
      else hold_v = sum_r;
    end
  end
  assign d_sh = sum_r[63:16];
  always_comb begin
    if (d_sh > 48'sh0000_7FFF_FFFF) drive_v = 32'sh7FFF_FFFF;
    else if (d_sh < -48'sh0000_8000_0000) drive_v = -32'sh8000_0000;
    else drive_v = d_sh[31:0];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_kp_r  <= bcc_pkg::RST_SPEED_KP;
      speed_ki_r  <= bcc_pkg::RST_SPEED_KI;
      angle_kp_r  <= bcc_pkg::RST_ANGLE_KP;
      angle_kd_r  <= bcc_pkg::RST_ANGLE_KD;
      rate_kp_r   <= bcc_pkg::RST_RATE_KP;
      rate_kd_r   <= bcc_pkg::RST_RATE_KD;
      angle_ref_r <= '0;
      rate_off_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bcc_pkg::REG_SPEED_KP:  speed_kp_r  <= cfg_data;
        bcc_pkg::REG_SPEED_KI:  speed_ki_r  <= cfg_data;
        bcc_pkg::REG_ANGLE_KP:  angle_kp_r  <= cfg_data;
        bcc_pkg::REG_ANGLE_KD:  angle_kd_r  <= cfg_data;
        bcc_pkg::REG_RATE_KP:   rate_kp_r   <= cfg_data;
        bcc_pkg::REG_RATE_KD:   rate_kd_r   <= cfg_data;
        bcc_pkg::REG_ANGLE_REF: angle_ref_r <= cfg_data[16:0];
        bcc_pkg::REG_RATE_OFF:  rate_off_r  <= cfg_data[15:0];
        default:                rate_off_r  <= rate_off_r;
      endcase
    end
  end

  // Loop state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      hold_r     <= '0;
      aprev_r    <= '0;
      rprev_r    <= '0;
    end else begin
      if (cmd.prep && op_r == bcc_pkg::OP_SPEED && e2 < bcc_pkg::ERR2_WIN &&
          e2 > -bcc_pkg::ERR2_WIN)
        integral_r <= bcc_pkg::sat48(int_sum);
      if (cmd.mid) begin
        aprev_r <= 40'(a_r);
        rprev_r <= g_v;
      end
      if (cmd.fin && op_r == bcc_pkg::OP_SPEED)
        hold_r <= hold_v[23:0];
    end
  end

  // Capture the item, form operands, accumulate products, register the result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_tuser;
      left_r   <= in_tdata[15:0];
      right_r  <= in_tdata[31:16];
      target_r <= in_tdata[47:32];
      pitch_r  <= in_tdata[64:48];
      gyro_r   <= in_tdata[80:65];
    end
    if (cmd.prep) begin
      e_r     <= 34'(e2) <<< 15;
      lim14_r <= e2 < -bcc_pkg::ERR2_WIN;
      a_r     <= a_v;
      da_r    <= 41'(a_v) - 41'(aprev_r);
    end
    if (cmd.mid) begin
      angle_r <= ang_v;
      g_r     <= g_v;
      dg_r    <= 49'(g_v) - 49'(rprev_r);
    end
    if (cmd.mul) acc_r <= acc_nxt;
    if (cmd.term) sum_r <= cmd.sel[0] ? sum_r + 64'(term) : 64'(term);
    if (cmd.fin) begin
      out_tuser_r <= op_r;
      if (op_r == bcc_pkg::OP_SPEED)
        out_tdata_r <= {3'b0, 32'b0, 48'b0, hold_v[20:0]};
      else
        out_tdata_r <= {3'b0, drive_v, angle_r, hold_r[20:0]};
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule

FILE: design/balance_cascade_controller_unit.sv
// Top level of the balance cascade controller: sequencer plus datapath.
//
//  channel | dir | handshake          | contents
//  in_     | in  | in_tvalid/tready   | tuser op, tdata counts, target, pitch, gyro
//  out_    | out | out_tvalid/tready  | tuser op_done, tdata speed, angle, drive
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_data (48 bits)
//
// An item is accepted only in the idle state, and the input is not ready again until
// its result has been registered (a speed item forms two products, an attitude item four).
// Each gain product takes four 48x17 digit passes through one shared multiplier
// and a term step that floors and limits it.
// Reset is synchronous and clears the loop state and restores the gains.
// A result held in the output register does not block acceptance of the next item;
// a second result waits until the first transaction completes.
module balance_cascade_controller_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bcc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bcc_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // left_count[15:0], right_count[31:16], speed_target[47:32], pitch_angle[64:48],
  // gyro_rate[80:65], zeros above
  input  logic [bcc_pkg::InDataW-1:0]   in_tdata,
  // op
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // speed_term[20:0], angle_term[68:21], balance_drive[100:69], zeros above
  output logic [bcc_pkg::OutDataW-1:0]  out_tdata,
  // op_done
  output logic                          out_tuser
);

  bcc_pkg::bcc_cmd_t  cmd;
  bcc_pkg::bcc_stat_t stat;

  bcc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bcc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: design/bcc_checker.sv
// Port-level checks of the balance cascade controller, bound to the top level.
module bcc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [bcc_pkg::OutDataW-1:0]  out_tdata,
  input logic                          out_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // Stay busy after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken while busy");

  // No result in the cycle after an item is taken while no result is pending
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result too early");

  // Speed results carry no attitude terms
  a_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == bcc_pkg::OP_SPEED) |->
      out_tdata[68:21] == '0 && out_tdata[100:69] == '0)
    else $error("speed result with attitude terms");

endmodule

bind balance_cascade_controller_unit bcc_checker u_bcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
